/* hdl/ctbd_pkg.sv */
// ctbd_pkg: shared types, register indexes, reset values and helper functions
// for the capacitive touch baseline detector. No dependencies.
package ctbd_pkg;

  localparam int NUM_BUTTONS_DEF = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_DETECT_THR     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_LIMIT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_PERIOD  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FAST_SHIFT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_SHIFT     = 3'd4;

  localparam logic [7:0] RST_DETECT_THR     = 8'd20;
  localparam logic [2:0] RST_DEBOUNCE_LIMIT = 3'd4;
  localparam logic [7:0] RST_UPDATE_PERIOD  = 8'd16;
  localparam logic [2:0] RST_FAST_SHIFT     = 3'd2;
  localparam logic [2:0] RST_SLOW_SHIFT     = 3'd4;

  typedef struct packed {
    logic [1:0] button;
    logic [9:0] adc_code;
  } in_t;

  typedef struct packed {
    logic       pressed;
    logic [7:0] scaled_sample;
  } out_t;

  typedef struct packed {
    logic [7:0] baseline;
    logic [2:0] debounce_count;
    logic       pressed_flag;
    logic [7:0] period_count;
  } entry_t;

  typedef struct packed {
    logic [7:0] detect_thr;
    logic [2:0] debounce_limit;
    logic [7:0] update_period;
    logic [2:0] fast_shift;
    logic [2:0] slow_shift;
  } cfg_t;

  // Saturating 10-to-8 bit scaling.
  function automatic logic [7:0] scale_code(input logic [9:0] code);
    logic [7:0] r;
    if (code[9]) begin
      r = {7'h7F, code[1]};
    end else begin
      r = code[8:1];
    end
    return r;
  endfunction

  // Right shift rounded by the last bit shifted out; zero shift passes through.
  function automatic logic [8:0] rounded_shift(input logic [7:0] v, input logic [2:0] s);
    logic [2:0] sm1;
    logic [8:0] r;
    sm1 = s - 3'd1;
    if (s == 3'd0) begin
      r = {1'b0, v};
    end else begin
      r = {1'b0, v >> s} + {8'd0, v[sm1]};
    end
    return r;
  endfunction

endpackage

/* hdl/ctbd_state_ram.sv */
// ctbd_state_ram: per-button state memory, one read and one write port,
// registered read, write-first forwarding, valid bits cleared at reset.
// Depends on ctbd_pkg.
module ctbd_state_ram #(
  parameter int DEPTH = ctbd_pkg::NUM_BUTTONS_DEF,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ctbd_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ctbd_pkg::entry_t wr_data
);

  ctbd_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid;
  ctbd_pkg::entry_t mem_q;
  ctbd_pkg::entry_t fwd_q;
  logic             fwd_hit;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      fwd_hit <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit <= wr_en && (wr_addr == rd_addr);
        vld_q   <= valid[rd_addr];
      end
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rd_data = fwd_q;
    end else if (vld_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

/* hdl/ctbd_update.sv */
// ctbd_update: debounce, period pacing and baseline filter for one sample.
// Depends on ctbd_pkg.
module ctbd_update (
  input  ctbd_pkg::entry_t cur,
  input  logic [7:0]       sample,
  input  logic             in_range,
  input  ctbd_pkg::cfg_t   cfg,
  output ctbd_pkg::entry_t nxt,
  output ctbd_pkg::out_t   res
);

  logic [7:0] val;
  logic       touch;
  logic [7:0] pc;
  logic       upd;
  logic [2:0] shift;
  logic [8:0] rs_val;
  logic [8:0] rs_smp;
  logic [8:0] filt;

  always_comb begin
    val   = (cur.baseline == 8'd0) ? sample : cur.baseline;
    // sample < val - threshold, signed; never true when val < threshold
    touch = ({1'b0, sample} + {1'b0, cfg.detect_thr}) < {1'b0, val};

    nxt = cur;
    if (touch) begin
      if (cur.debounce_count < cfg.debounce_limit) begin
        nxt.debounce_count = cur.debounce_count + 3'd1;
      end else begin
        nxt.pressed_flag = 1'b1;
      end
    end else begin
      if (cur.debounce_count != 3'd0) begin
        nxt.debounce_count = cur.debounce_count - 3'd1;
      end else begin
        nxt.pressed_flag = 1'b0;
      end
    end

    pc     = cur.period_count + 8'd1;
    upd    = pc >= cfg.update_period;
    shift  = nxt.pressed_flag ? cfg.slow_shift : cfg.fast_shift;
    rs_val = ctbd_pkg::rounded_shift(val, shift);
    rs_smp = ctbd_pkg::rounded_shift(sample, shift);
    filt   = {1'b0, val} - rs_val + rs_smp;

    if (upd) begin
      nxt.period_count = 8'd0;
      nxt.baseline     = filt[7:0];
    end else begin
      nxt.period_count = pc;
    end

    res.pressed       = in_range & nxt.pressed_flag;
    res.scaled_sample = sample;
  end

endmodule

/* hdl/cap_touch_baseline_detector_top.sv */
// Capacitive touch baseline detector with debounce, top level.
// Depends on ctbd_pkg, ctbd_state_ram and ctbd_update.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one request per sample: a
//   button index and a raw 10-bit converter code. out channel
//   (out_valid/out_ready/out_data) returns one result per request: the
//   debounced pressed state of that button and the 8-bit scaled sample.
//   Results come back in request order.
//   An accepted request waits in the read stage, then its result is
//   registered. Throughput: one request per cycle, back to back, on the
//   same or different buttons; the state memory read-modify-write uses
//   write-first forwarding, so consecutive samples of one button chain.
//   When out_ready is low on a held result, it stays, the request behind it
//   waits in the read stage and in_ready drops until the result is taken.
//   Reset: all per-button state reads as zero (valid bits, no clearing
//   sweep), config registers return to defaults, both channels go idle.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle,
//   to be used only while the block is idle.
module cap_touch_baseline_detector_top #(
  parameter int NUM_BUTTONS = ctbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ctbd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ctbd_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [ctbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ctbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  ctbd_pkg::cfg_t   cfg;
  logic             accept;
  logic             advance;
  logic             in_range;
  logic             s1_valid;
  logic             s1_in_range;
  logic [AW-1:0]    s1_addr;
  logic [7:0]       s1_sample;
  ctbd_pkg::entry_t cur;
  ctbd_pkg::entry_t nxt;
  ctbd_pkg::out_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_thr      <= ctbd_pkg::RST_DETECT_THR;
      cfg.debounce_limit  <= ctbd_pkg::RST_DEBOUNCE_LIMIT;
      cfg.update_period   <= ctbd_pkg::RST_UPDATE_PERIOD;
      cfg.fast_shift      <= ctbd_pkg::RST_FAST_SHIFT;
      cfg.slow_shift      <= ctbd_pkg::RST_SLOW_SHIFT;
    end else if (cfg_we) begin
      case (cfg_addr)
        ctbd_pkg::REG_DETECT_THR:      cfg.detect_thr      <= cfg_wdata;
        ctbd_pkg::REG_DEBOUNCE_LIMIT:  cfg.debounce_limit  <= cfg_wdata[2:0];
        ctbd_pkg::REG_UPDATE_PERIOD:   cfg.update_period   <= cfg_wdata;
        ctbd_pkg::REG_FAST_SHIFT:      cfg.fast_shift      <= cfg_wdata[2:0];
        ctbd_pkg::REG_SLOW_SHIFT:      cfg.slow_shift      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign in_range = 32'(in_data.button) < NUM_BUTTONS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= in_range;
      s1_addr     <= AW'(in_data.button);
      s1_sample   <= ctbd_pkg::scale_code(in_data.adc_code);
    end
  end

  ctbd_state_ram #(
    .DEPTH (NUM_BUTTONS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (AW'(in_data.button)),
    .rd_data (cur),
    .wr_en   (advance && s1_in_range),
    .wr_addr (s1_addr),
    .wr_data (nxt)
  );

  ctbd_update u_update (
    .cur      (cur),
    .sample   (s1_sample),
    .in_range (s1_in_range),
    .cfg      (cfg),
    .nxt      (nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("in_ready low while pipeline not full");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced request produced no result");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost in read stage");
`endif

endmodule

/* tb/tb_cap_touch_baseline_detector_top.sv */
`timescale 1ns / 1ps
// tb_cap_touch_baseline_detector_top: self-checking bench for the touch detector.
// Depends on ctbd_pkg and cap_touch_baseline_detector_top; predicts every result
// from its own per-button baseline/debounce tracker and checks them in order.
module tb_cap_touch_baseline_detector_top;

  localparam int NBTN = 4;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  ctbd_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ctbd_pkg::out_t                  out_data;
  logic                            cfg_we = 1'b0;
  logic [ctbd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ctbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cap_touch_baseline_detector_top #(.NUM_BUTTONS(NBTN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // tracker copy of config and per-button state
  logic [7:0] thr_r;
  logic [2:0] lim_r;
  logic [7:0] upd_r;
  logic [2:0] fast_r;
  logic [2:0] slow_r;
  logic [7:0] base_m  [NBTN];
  logic [2:0] cnt_m   [NBTN];
  logic       press_m [NBTN];
  logic [7:0] per_m   [NBTN];

  ctbd_pkg::out_t pending_touch [$];
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic touching [NBTN];
  int   nominal [NBTN];

  function automatic logic [7:0] to_sample(input logic [9:0] code);
    return code[9] ? {7'h7F, code[1]} : code[8:1];
  endfunction

  function automatic int shr_round(input int v, input logic [2:0] s);
    if (s == 3'd0) return v;
    return (v >> s) + ((v >> (s - 1)) & 1);
  endfunction

  task automatic clear_tracker();
    thr_r  = ctbd_pkg::RST_DETECT_THR;
    lim_r  = ctbd_pkg::RST_DEBOUNCE_LIMIT;
    upd_r  = ctbd_pkg::RST_UPDATE_PERIOD;
    fast_r = ctbd_pkg::RST_FAST_SHIFT;
    slow_r = ctbd_pkg::RST_SLOW_SHIFT;
    for (int b = 0; b < NBTN; b++) begin
      base_m[b]   = '0;
      cnt_m[b]    = '0;
      press_m[b]  = 1'b0;
      per_m[b]    = '0;
      touching[b] = 1'b0;
      nominal[b]  = 400;
    end
  endtask

  task automatic track_sample(input ctbd_pkg::in_t req, output ctbd_pkg::out_t res);
    logic [7:0] smp;
    logic [2:0] sh;
    int         b;
    int         val;
    int         pc;
    smp = to_sample(req.adc_code);
    b = req.button;
    val = base_m[b];
    if (val == 0) val = smp;
    if (int'(smp) < val - int'(thr_r)) begin
      if (cnt_m[b] < lim_r) cnt_m[b] = cnt_m[b] + 3'd1;
      else press_m[b] = 1'b1;
    end else begin
      if (cnt_m[b] != 3'd0) cnt_m[b] = cnt_m[b] - 3'd1;
      else press_m[b] = 1'b0;
    end
    pc = (per_m[b] + 1) & 255;
    if (pc >= int'(upd_r)) begin
      sh = press_m[b] ? slow_r : fast_r;
      per_m[b] = 8'd0;
      base_m[b] = 8'(val - shr_round(val, sh) + shr_round(int'(smp), sh));
    end else begin
      per_m[b] = 8'(pc);
    end
    res.pressed = press_m[b];
    res.scaled_sample = smp;
  endtask

  // leaves cfg_we high; caller lowers it after the last write
  task automatic put_reg(input logic [ctbd_pkg::CFG_ADDR_W-1:0] addr,
                         input logic [ctbd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      ctbd_pkg::REG_DETECT_THR:     thr_r  = data;
      ctbd_pkg::REG_DEBOUNCE_LIMIT: lim_r  = data[2:0];
      ctbd_pkg::REG_UPDATE_PERIOD:  upd_r  = data;
      ctbd_pkg::REG_FAST_SHIFT:     fast_r = data[2:0];
      ctbd_pkg::REG_SLOW_SHIFT:     slow_r = data[2:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [7:0] thr, input logic [2:0] lim, input logic [7:0] upd,
                            input logic [2:0] fs, input logic [2:0] ss);
    put_reg(ctbd_pkg::REG_DETECT_THR, thr);
    put_reg(ctbd_pkg::REG_DEBOUNCE_LIMIT, 8'(lim));
    put_reg(ctbd_pkg::REG_UPDATE_PERIOD, upd);
    put_reg(ctbd_pkg::REG_FAST_SHIFT, 8'(fs));
    put_reg(ctbd_pkg::REG_SLOW_SHIFT, 8'(ss));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic [1:0] btn, input logic [9:0] code);
    ctbd_pkg::in_t  req;
    ctbd_pkg::out_t res;
    req.button = btn;
    req.adc_code = code;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    track_sample(req, res);
    pending_touch.push_back(res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_touch.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly steady levels with touch bursts per button, some raw noise
  task automatic send_random();
    int b;
    int code;
    int drop;
    b = $urandom_range(0, NBTN - 1);
    if ($urandom_range(0, 11) == 0) touching[b] = !touching[b];
    if ($urandom_range(0, 99) < 15) begin
      code = $urandom_range(0, 1023);
    end else if (touching[b]) begin
      drop = 2 * (int'(thr_r) + int'($urandom_range(1, 40)));
      code = (nominal[b] > drop) ? nominal[b] - drop : int'($urandom_range(0, 15));
    end else begin
      code = nominal[b] + int'($urandom_range(0, 8)) - 4;
    end
    if (code > 1023) code = 1023;
    if (code < 0) code = 0;
    send_sample(2'(b), 10'(code));
  endtask

  task automatic test_scaling();
    send_sample(2'd0, 10'd0);
    send_sample(2'd1, 10'h3FF);
    send_sample(2'd2, 10'h200);
    send_sample(2'd3, 10'h1FF);
    send_sample(2'd0, 10'h155);
    send_sample(2'd1, 10'h2AA);
    settle();
  endtask

  task automatic test_press_release();
    write_regs(8'd20, 3'd2, 8'd1, 3'd1, 3'd7);
    repeat (2) send_sample(2'd1, 10'd400);
    repeat (4) send_sample(2'd1, 10'd40);
    repeat (3) send_sample(2'd1, 10'd400);
    settle();
  endtask

  // zero period and zero shift, then all-high extremes
  task automatic test_extreme_config();
    write_regs(8'd0, 3'd0, 8'd0, 3'd0, 3'd0);
    send_sample(2'd3, 10'd800);
    send_sample(2'd3, 10'd200);
    send_sample(2'd3, 10'd100);
    send_sample(2'd3, 10'd100);
    send_sample(2'd3, 10'd300);
    settle();
    write_regs(8'd255, 3'd7, 8'd255, 3'd7, 3'd7);
    send_sample(2'd0, 10'h3FF);
    send_sample(2'd0, 10'd0);
    send_sample(2'd2, 10'd2);
    settle();
  endtask

  task automatic test_unmapped_regs();
    for (int a = int'(ctbd_pkg::REG_SLOW_SHIFT) + 1; a < 2 ** ctbd_pkg::CFG_ADDR_W; a++)
      put_reg(ctbd_pkg::CFG_ADDR_W'(a), 8'hFF);
    cfg_we <= 1'b0;
    send_sample(2'd1, 10'd500);
    send_sample(2'd1, 10'd10);
    settle();
  endtask

  task automatic test_random_traffic(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int b = 0; b < NBTN; b++) begin
      nominal[b] = $urandom_range(100, 1000);
      touching[b] = 1'b0;
    end
    repeat (n) send_random();
    settle();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    ctbd_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_touch.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pressed=%0b sample=%0d",
                 $time, out_data.pressed, out_data.scaled_sample);
        errors++;
      end else begin
        want = pending_touch.pop_front();
        if (out_data.pressed !== want.pressed) begin
          $display("%0t: pressed mismatch, expected %0b, actual %0b",
                   $time, want.pressed, out_data.pressed);
          errors++;
        end
        if (out_data.scaled_sample !== want.scaled_sample) begin
          $display("%0t: scaled_sample mismatch, expected %0d, actual %0d",
                   $time, want.scaled_sample, out_data.scaled_sample);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_tracker();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_scaling();
    test_press_release();
    test_extreme_config();
    test_unmapped_regs();
    write_regs(ctbd_pkg::RST_DETECT_THR, ctbd_pkg::RST_DEBOUNCE_LIMIT,
               ctbd_pkg::RST_UPDATE_PERIOD, ctbd_pkg::RST_FAST_SHIFT,
               ctbd_pkg::RST_SLOW_SHIFT);
    test_random_traffic(125, 0, 0);
    write_regs(8'd0, 3'd0, 8'd1, 3'd1, 3'd1);
    test_random_traffic(125, 71, 0);
    write_regs(8'd255, 3'd7, 8'd255, 3'd7, 3'd7);
    test_random_traffic(125, 0, 71);
    write_regs(8'($urandom_range(0, 80)), 3'($urandom_range(0, 7)), 8'($urandom_range(1, 8)),
               3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)));
    test_random_traffic(125, 18, 18);
    write_regs(8'($urandom_range(0, 60)), 3'($urandom_range(0, 7)), 8'($urandom_range(0, 12)),
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    test_random_traffic(125, 0, 0);
    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
